FILE: hdl/data_run_list_decoder_macros.svh
// Assertion macros used by the checker of the run list decoder.
`ifndef DATA_RUN_LIST_DECODER_MACROS_SVH
`define DATA_RUN_LIST_DECODER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define DRLD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on the rising clock, off during reset.
`define DRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: hdl/drld_pkg.sv
// ----------------------------------------------------------------------------
// drld_pkg
// Types and constants of the data run list decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package drld_pkg;

  typedef logic [63:0] cluster_t;
  typedef logic [7:0]  list_byte_t;
  typedef logic [3:0]  nibble_t;

  localparam list_byte_t EndHeader = 8'h00;
  localparam nibble_t    NibMax    = 4'd8;

  typedef enum logic [3:0] {
    PhHeader = 4'b0001,
    PhLength = 4'b0010,
    PhOffset = 4'b0100,
    PhHalted = 4'b1000
  } phase_e;

  typedef struct packed {
    cluster_t clusters;
    cluster_t base_cluster;
    logic     sparse;
    logic     done;
    logic     error;
  } run_t;

endpackage

`default_nettype wire

FILE: hdl/drld_if.sv
// ----------------------------------------------------------------------------
// drld_if
// Valid/ready channels for run list bytes and decoded runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface drld_list_if;
  logic                valid;
  logic                ready;
  drld_pkg::list_byte_t list_byte;
  logic                list_start;

  modport source (output valid, output list_byte, output list_start, input ready);
  modport sink   (input valid, input list_byte, input list_start, output ready);
endinterface

interface drld_run_if;
  logic              valid;
  logic              ready;
  drld_pkg::cluster_t run_clusters;
  drld_pkg::cluster_t run_start_cluster;
  logic              run_sparse;
  logic              list_done;
  logic              list_error;

  modport source (
    output valid, output run_clusters, output run_start_cluster,
    output run_sparse, output list_done, output list_error, input ready
  );
  modport sink (
    input valid, input run_clusters, input run_start_cluster,
    input run_sparse, input list_done, input list_error, output ready
  );
endinterface

`default_nettype wire

FILE: hdl/drld_core.sv
// ----------------------------------------------------------------------------
// drld_core
// Decode state: header, little-endian length and offset bytes, running start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drld_core (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 accept_i,
  input  wire drld_pkg::list_byte_t list_byte_i,
  input  wire logic                 list_start_i,
  output logic                      push_o,
  output drld_pkg::run_t            run_o
);

  drld_pkg::phase_e   phase_q, phase_d, ph;
  drld_pkg::nibble_t  len_left_q, len_left_d;
  drld_pkg::nibble_t  off_left_q, off_left_d;
  drld_pkg::nibble_t  off_size_q, off_size_d;
  logic [2:0]         shift_q, shift_d;
  drld_pkg::cluster_t len_acc_q, len_acc_d;
  drld_pkg::cluster_t off_acc_q, off_acc_d;
  drld_pkg::cluster_t prev_q, prev_d;

  drld_pkg::cluster_t prev, len_merge, off_merge, delta, sign_mask;
  drld_pkg::nibble_t  lo, hi, len_left_dec, off_left_dec;
  logic [5:0]         lane_sh, ext_sh, sign_idx;

  always_comb begin
    ph           = list_start_i ? drld_pkg::PhHeader : phase_q;
    prev         = list_start_i ? '0 : prev_q;
    lo           = list_byte_i[3:0];
    hi           = list_byte_i[7:4];
    lane_sh      = {shift_q, 3'b000};
    len_merge    = len_acc_q | (drld_pkg::cluster_t'(list_byte_i) << lane_sh);
    off_merge    = off_acc_q | (drld_pkg::cluster_t'(list_byte_i) << lane_sh);
    len_left_dec = len_left_q - 4'd1;
    off_left_dec = off_left_q - 4'd1;
    ext_sh       = {off_size_q[2:0], 3'b000};
    sign_idx     = ext_sh - 6'd1;
    sign_mask    = {64{1'b1}} << ext_sh;
    delta        = off_merge;
    if ((off_size_q != drld_pkg::NibMax) && off_merge[sign_idx]) begin
      delta = off_merge | sign_mask;
    end

    phase_d    = phase_q;
    len_left_d = len_left_q;
    off_left_d = off_left_q;
    off_size_d = off_size_q;
    shift_d    = shift_q;
    len_acc_d  = len_acc_q;
    off_acc_d  = off_acc_q;
    prev_d     = prev_q;
    push_o     = 1'b0;
    run_o      = '0;

    if (accept_i) begin
      phase_d = ph;
      prev_d  = prev;
      unique case (ph)
        drld_pkg::PhHeader: begin
          if (list_byte_i == drld_pkg::EndHeader) begin
            phase_d    = drld_pkg::PhHalted;
            push_o     = 1'b1;
            run_o.done = 1'b1;
          end else if (lo == 4'd0 || lo > drld_pkg::NibMax || hi > drld_pkg::NibMax) begin
            phase_d     = drld_pkg::PhHalted;
            push_o      = 1'b1;
            run_o.error = 1'b1;
          end else begin
            len_left_d = lo;
            off_left_d = hi;
            off_size_d = hi;
            shift_d    = '0;
            len_acc_d  = '0;
            off_acc_d  = '0;
            phase_d    = drld_pkg::PhLength;
          end
        end
        drld_pkg::PhLength: begin
          len_acc_d  = len_merge;
          len_left_d = len_left_dec;
          shift_d    = shift_q + 3'd1;
          if (len_left_dec == 4'd0) begin
            shift_d = '0;
            if (off_size_q == 4'd0) begin
              phase_d        = drld_pkg::PhHeader;
              push_o         = 1'b1;
              run_o.clusters = len_merge;
              run_o.sparse   = 1'b1;
            end else begin
              phase_d = drld_pkg::PhOffset;
            end
          end
        end
        drld_pkg::PhOffset: begin
          off_acc_d  = off_merge;
          off_left_d = off_left_dec;
          shift_d    = shift_q + 3'd1;
          if (off_left_dec == 4'd0) begin
            shift_d            = '0;
            prev_d             = prev + delta;
            phase_d            = drld_pkg::PhHeader;
            push_o             = 1'b1;
            run_o.clusters     = len_acc_q;
            run_o.base_cluster = prev + delta;
          end
        end
        default: begin
          phase_d = ph;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= drld_pkg::PhHeader;
      len_left_q <= '0;
      off_left_q <= '0;
      off_size_q <= '0;
      shift_q    <= '0;
      prev_q     <= '0;
    end else begin
      phase_q    <= phase_d;
      len_left_q <= len_left_d;
      off_left_q <= off_left_d;
      off_size_q <= off_size_d;
      shift_q    <= shift_d;
      prev_q     <= prev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_acc_q <= len_acc_d;
    off_acc_q <= off_acc_d;
  end

endmodule

`default_nettype wire

FILE: hdl/drld_obuf.sv
// ----------------------------------------------------------------------------
// drld_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module drld_obuf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire drld_pkg::run_t run_i,
  input  wire logic           pop_ready_i,
  output logic                space_o,
  output logic                valid_o,
  output drld_pkg::run_t      run_o
);

  logic           out_v_q, out_v_d, skid_v_q, skid_v_d;
  drld_pkg::run_t out_q, out_d, skid_q, skid_d;
  logic           pop;

  assign pop     = out_v_q && pop_ready_i;
  assign space_o = !skid_v_q;
  assign valid_o = out_v_q;
  assign run_o   = out_q;

  always_comb begin
    out_v_d  = out_v_q;
    skid_v_d = skid_v_q;
    out_d    = out_q;
    skid_d   = skid_q;
    if (!out_v_q) begin
      if (push_i) begin
        out_v_d = 1'b1;
        out_d   = run_i;
      end
    end else if (pop) begin
      if (skid_v_q) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else if (push_i) begin
        out_d = run_i;
      end else begin
        out_v_d = 1'b0;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

FILE: hdl/data_run_list_decoder.sv
// ----------------------------------------------------------------------------
// data_run_list_decoder
// Run list decoder: one byte per transaction in, one run or status result out.
// ----------------------------------------------------------------------------
// The block takes one run list byte every clock cycle while list_i.ready is
// high and registers each result (run, end of list, or bad header) in the
// output register, or in the skid register while the output is held. The
// rate of one byte per cycle is set by the decode step and the start-cluster
// adder. The skid register behind the output register keeps list_i.ready
// high while one result waits; ready drops only when two results are held.
`timescale 1ns / 1ps
`default_nettype none

module data_run_list_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  drld_list_if.sink list_i,
  drld_run_if.source run_o
);

  logic           accept, push, space;
  drld_pkg::run_t core_run, buf_run;

  assign list_i.ready = space;
  assign accept       = list_i.valid && space;

  drld_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .list_byte_i  (list_i.list_byte),
    .list_start_i (list_i.list_start),
    .push_o       (push),
    .run_o        (core_run)
  );

  drld_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .run_i       (core_run),
    .pop_ready_i (run_o.ready),
    .space_o     (space),
    .valid_o     (run_o.valid),
    .run_o       (buf_run)
  );

  assign run_o.run_clusters      = buf_run.clusters;
  assign run_o.run_start_cluster = buf_run.base_cluster;
  assign run_o.run_sparse        = buf_run.sparse;
  assign run_o.list_done         = buf_run.done;
  assign run_o.list_error        = buf_run.error;

endmodule

`default_nettype wire

FILE: hdl/drld_checker.sv
// ----------------------------------------------------------------------------
// drld_checker
// Port-level checks of the run list decoder, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "data_run_list_decoder_macros.svh"

module drld_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_i,
  input wire drld_pkg::list_byte_t list_byte_i,
  input wire logic                 list_start_i,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire drld_pkg::cluster_t   run_clusters_i,
  input wire drld_pkg::cluster_t   run_start_cluster_i,
  input wire logic                 run_sparse_i,
  input wire logic                 list_done_i,
  input wire logic                 list_error_i
);

  `DRLD_ASSERT_SAME(a_flags_exclusive, clk_i, rst_ni, out_valid_i,
                    $onehot0({run_sparse_i, list_done_i, list_error_i}))

  `DRLD_ASSERT_SAME(a_end_result_zero, clk_i, rst_ni,
                    out_valid_i && (list_done_i || list_error_i),
                    run_clusters_i == 64'd0 && run_start_cluster_i == 64'd0)

  `DRLD_ASSERT_NEXT(a_start_end_reports, clk_i, rst_ni,
                    in_valid_i && in_ready_i && list_start_i
                      && list_byte_i == drld_pkg::EndHeader,
                    out_valid_i)

  `DRLD_ASSERT_NEXT(a_stalled_result_holds, clk_i, rst_ni,
                    out_valid_i && !out_ready_i,
                    out_valid_i && $stable(run_clusters_i) && $stable(run_start_cluster_i))

endmodule

bind data_run_list_decoder drld_checker u_drld_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_valid_i          (list_i.valid),
  .in_ready_i          (list_i.ready),
  .list_byte_i         (list_i.list_byte),
  .list_start_i        (list_i.list_start),
  .out_valid_i         (run_o.valid),
  .out_ready_i         (run_o.ready),
  .run_clusters_i      (run_o.run_clusters),
  .run_start_cluster_i (run_o.run_start_cluster),
  .run_sparse_i        (run_o.run_sparse),
  .list_done_i         (run_o.list_done),
  .list_error_i        (run_o.list_error)
);

`default_nettype wire
